/* sv/aid_pkg.sv */
// Shared constants and types of the address-to-ID assigner.
package aid_pkg;

   localparam int CAPACITY    = 64;
   localparam int KEY_WIDTH   = 64;
   localparam int KEY_FIELD_W = 64;
   localparam int ID_W        = 7;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int COUNT_W     = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } seq_state_type;

   typedef struct packed {
      logic [ID_W-1:0] assigned_id;
      logic            newly_assigned;
      logic            table_full;
   } result_type;

   // Result hand-off from the sequencer to the output register.
   typedef struct packed {
      logic       valid;
      result_type res;
   } seq_out_type;

endpackage

/* sv/aid_req_if.sv */
// Request channel interface: one address key per beat.
interface aid_req_if
   import aid_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [KEY_FIELD_W-1:0] key_address;

   modport source (output valid, output key_address, input ready);
   modport sink   (input valid, input key_address, output ready);
endinterface

/* sv/aid_rsp_if.sv */
// Response channel interface: one assigned ID per beat.
interface aid_rsp_if
   import aid_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] assigned_id;
   logic            newly_assigned;
   logic            table_full;

   modport source (output valid, output assigned_id, output newly_assigned,
                   output table_full, input ready);
   modport sink   (input valid, input assigned_id, input newly_assigned,
                   input table_full, output ready);
endinterface

/* sv/aid_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module aid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/aid_seq.sv */
// Search sequencer: walks the key table through one shared comparator.
module aid_seq
   import aid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [KEY_FIELD_W-1:0] req_key,
   output logic                   req_ready,
   input  logic                   res_free,
   output seq_out_type            seq_out
);

   seq_state_type state_ff, state_in;

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [COUNT_W-1:0]   used_ff, used_in;
   logic [COUNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [COUNT_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   result_type           res_ff, res_in;

   logic                 rd_en;
   logic                 wr_en;
   logic [KEY_WIDTH-1:0] rd_data;
   logic                 hit;

   aid_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (used_ff[ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // the one comparator, fed one stored key per cycle
   assign hit = cmp_valid_ff && (rd_data == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      used_in      = used_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      res_in       = res_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      req_ready    = 1'b0;
      seq_out      = '{valid: 1'b0, res: res_ff};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in    = req_key[KEY_WIDTH-1:0];
               rd_idx_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en        = rd_idx_ff < used_ff;
            cmp_valid_in = rd_en;
            cmp_idx_in   = rd_idx_ff;
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            priority if (hit) begin
               res_in.assigned_id    = ID_W'(cmp_idx_ff + 1'b1);
               res_in.newly_assigned = 1'b0;
               res_in.table_full     = 1'b0;
               cmp_valid_in          = 1'b0;
               state_in              = ST_RESULT;
            end else if (!rd_en && !cmp_valid_ff) begin
               // search exhausted: store the key or report full
               if (used_ff == COUNT_W'(CAPACITY)) begin
                  res_in.assigned_id    = '0;
                  res_in.newly_assigned = 1'b0;
                  res_in.table_full     = 1'b1;
               end else begin
                  wr_en                 = 1'b1;
                  used_in               = used_ff + 1'b1;
                  res_in.assigned_id    = ID_W'(used_ff + 1'b1);
                  res_in.newly_assigned = 1'b1;
                  res_in.table_full     = 1'b0;
               end
               state_in = ST_RESULT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_RESULT: begin
            // hold until the output register can take the beat
            if (res_free) begin
               seq_out.valid = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (used_ff < COUNT_W'(CAPACITY)) && !hit)
      else $error("key stored into a full table or on a hit");

   a_write_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> used_ff == $past(used_ff) + 1'b1)
      else $error("entry count did not advance after a store");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      seq_out.valid |-> !(seq_out.res.newly_assigned && seq_out.res.table_full))
      else $error("new and full flags raised together");

endmodule

/* sv/address_to_id_assigner_core.sv */
// Top level of the address-to-ID assigner: sequencer plus output register.
//
// Each request beat carries an address key; each response beat returns the
// ID of that key, counting up from 1 in order of first appearance, with
// newly_assigned set when the key was stored by this request. Once all
// CAPACITY entries are used a further new key returns ID 0 with table_full
// set and is not stored. Only the low KEY_WIDTH bits of the key take part.
// One request at a time: a request is taken only while the sequencer is idle,
// and the search reads one stored entry per cycle through a single-port-read
// key RAM into one comparator, so a key that misses is compared against every
// used entry before its result enters the output register, while a hit on
// entry i ends the search early. A result that finds the output register
// still occupied holds the sequencer until the register drains. The output
// register lets the next request be taken while a response still waits for
// rsp ready.
// After reset the table is empty; no clearing pass is needed.
module address_to_id_assigner_core
   import aid_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   aid_req_if.sink   req_chan,
   aid_rsp_if.source rsp_chan
);

   seq_out_type seq_out;
   logic        res_free;
   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff, out_res_in;

   // the output register is free when empty or draining this cycle
   assign res_free = !out_valid_ff || rsp_chan.ready;

   aid_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_key   (req_chan.key_address),
      .req_ready (req_chan.ready),
      .res_free  (res_free),
      .seq_out   (seq_out)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      priority if (seq_out.valid) begin
         // load a fresh beat
         out_valid_in = 1'b1;
         out_res_in   = seq_out.res;
      end else if (rsp_chan.ready) begin
         // drop the beat just taken
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.assigned_id    = out_res_ff.assigned_id;
   assign rsp_chan.newly_assigned = out_res_ff.newly_assigned;
   assign rsp_chan.table_full     = out_res_ff.table_full;

endmodule
